// ===== src/capture_trigger_policy_unit_assert.svh =====
// Assertion macros shared by the capture trigger policy RTL.
// Every macro expects signals named clk and rst_n in the including module.
`ifndef CAPTURE_TRIGGER_POLICY_UNIT_ASSERT_SVH
`define CAPTURE_TRIGGER_POLICY_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CTP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CTP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ctp_pkg.sv =====
// Shared types and constants for the capture trigger policy unit.
// Depends on nothing; the three RTL modules refer to it by scoped names.
package ctp_pkg;

    typedef struct packed {
        logic [31:0] time_ms;
        logic        has_detection;
        logic [15:0] top_score;
    } in_item_t;

    typedef struct packed {
        logic        save_frame;
        logic [2:0]  save_reason;
        logic [1:0]  rung_index;
        logic [15:0] bursts_cancelled;
    } out_item_t;

    // Scalar configuration seen by the decision logic.
    typedef struct packed {
        logic [1:0]  capture_mode;
        logic [15:0] min_interval_ms;
        logic [15:0] confidence_threshold;
        logic [2:0]  ladder_count;
        logic [7:0]  burst_frames;
        logic [15:0] burst_interval_ms;
        logic [23:0] cooldown_ms;
    } cfg_t;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_CAPTURE_MODE     = 3'd0;
    localparam logic [2:0] REG_MIN_INTERVAL     = 3'd1;
    localparam logic [2:0] REG_CONF_THRESHOLD   = 3'd2;
    localparam logic [2:0] REG_LADDER_COUNT     = 3'd3;
    localparam logic [2:0] REG_LADDER_THRESH    = 3'd4;
    localparam logic [2:0] REG_LADDER_INTERVALS = 3'd5;
    localparam logic [2:0] REG_BURST_FRAMES     = 3'd6;
    localparam logic [2:0] REG_BURST_INTERVAL   = 3'd7;

    localparam logic [1:0] MODE_TIMED     = 2'd0;
    localparam logic [1:0] MODE_DETECTION = 2'd1;
    localparam logic [1:0] MODE_BURST     = 2'd2;

    localparam logic [2:0] REASON_NONE      = 3'd0;
    localparam logic [2:0] REASON_TIMED     = 3'd1;
    localparam logic [2:0] REASON_DETECTION = 3'd2;
    localparam logic [2:0] REASON_BURST     = 3'd3;
    localparam logic [2:0] REASON_LADDER    = 3'd4;

    localparam logic [2:0]  RUNG_BURST       = 3'd7;
    localparam logic [31:0] FADE_MS          = 32'd2000;
    localparam logic [23:0] MIN_COOLDOWN_MS  = 24'd1000;
    localparam logic [15:0] CONF_THRESH_INIT = 16'd32768;
    localparam logic [15:0] CANCEL_MAX       = 16'hFFFF;

endpackage

// ===== src/capture_trigger_policy_unit.sv =====
// Capture trigger policy unit: input register, one-pass save decision, result register.
// A frame accepted into the input register is decided and written to the result register when it is free.
// Throughput: one frame per cycle while out_stall is low; the decision path is 32-bit time
// differences, compares, an 8 by 16 bit cooldown product and a four-rung priority select.
// Reset: asynchronous, active low; clears all policy state and pipeline valids and
// loads the configuration reset values; a write applies to every frame decided after it.
`include "capture_trigger_policy_unit_assert.svh"

module capture_trigger_policy_unit #(
    parameter int LADDER_ENTRIES = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  ctp_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output ctp_pkg::out_item_t  out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [63:0]         cfg_data
);

    ctp_pkg::cfg_t      cfg;
    logic [15:0]        ladder_thr [LADDER_ENTRIES];
    logic [15:0]        ladder_ivl [LADDER_ENTRIES];
    ctp_pkg::in_item_t  s1_data_reg;
    logic               s1_valid_reg, s1_valid_next;
    ctp_pkg::out_item_t out_data_reg;
    logic               out_valid_reg, out_valid_next;
    ctp_pkg::out_item_t result;
    logic               out_free;
    logic               fire;
    logic               in_take;

    ctp_cfg #(.LADDER_ENTRIES(LADDER_ENTRIES)) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cfg        (cfg),
        .ladder_thr (ladder_thr),
        .ladder_ivl (ladder_ivl)
    );

    ctp_policy #(.LADDER_ENTRIES(LADDER_ENTRIES)) u_policy (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .item       (s1_data_reg),
        .cfg        (cfg),
        .ladder_thr (ladder_thr),
        .ladder_ivl (ladder_ivl),
        .result     (result)
    );

    // The held frame is decided whenever the result register can take it.
    assign out_free = !out_valid_reg || !out_stall;
    assign fire     = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (fire)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_data_reg <= in_data;
        end
        if (fire)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `CTP_ASSERT_SAME(a_no_overwrite, out_valid_reg && out_stall, !fire, "result overwritten while stalled")
    `CTP_ASSERT_SAME(a_reason_matches_save, out_valid_reg, out_data_reg.save_frame == (out_data_reg.save_reason != ctp_pkg::REASON_NONE), "save flag and reason disagree")
    `CTP_ASSERT_SAME(a_rung_only_ladder, out_valid_reg && out_data_reg.save_reason != ctp_pkg::REASON_LADDER, out_data_reg.rung_index == 2'd0, "rung index set without a ladder save")

endmodule

// ===== src/ctp_cfg.sv =====
// Configuration register file of the capture trigger policy unit.
// Depends on ctp_pkg; also derives the burst cooldown from the burst settings.
module ctp_cfg #(
    parameter int LADDER_ENTRIES = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [63:0]         cfg_data,
    output ctp_pkg::cfg_t       cfg,
    output logic [15:0]         ladder_thr [LADDER_ENTRIES],
    output logic [15:0]         ladder_ivl [LADDER_ENTRIES]
);

    logic [1:0]  mode_reg;
    logic [15:0] min_interval_reg;
    logic [15:0] conf_thr_reg;
    logic [2:0]  ladder_count_reg;
    logic [7:0]  burst_frames_reg;
    logic [15:0] burst_interval_reg;
    logic [23:0] cooldown_ms;
    logic [15:0] ladder_thr_reg [LADDER_ENTRIES];
    logic [15:0] ladder_ivl_reg [LADDER_ENTRIES];
    logic [7:0]  frames_eff;
    logic [15:0] interval_eff;
    logic [23:0] span;
    logic        wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg           <= ctp_pkg::MODE_TIMED;
            min_interval_reg   <= '0;
            conf_thr_reg       <= ctp_pkg::CONF_THRESH_INIT;
            ladder_count_reg   <= '0;
            burst_frames_reg   <= '0;
            burst_interval_reg <= '0;
            for (int i = 0; i < LADDER_ENTRIES; i++)
            begin
                ladder_thr_reg[i] <= '0;
                ladder_ivl_reg[i] <= '0;
            end
        end
        else if (wr)
        begin
            unique case (cfg_index)
                ctp_pkg::REG_CAPTURE_MODE:     mode_reg           <= cfg_data[1:0];
                ctp_pkg::REG_MIN_INTERVAL:     min_interval_reg   <= cfg_data[15:0];
                ctp_pkg::REG_CONF_THRESHOLD:   conf_thr_reg       <= cfg_data[15:0];
                ctp_pkg::REG_LADDER_COUNT:     ladder_count_reg   <= cfg_data[2:0];
                ctp_pkg::REG_LADDER_THRESH:
                begin
                    for (int i = 0; i < LADDER_ENTRIES; i++)
                    begin
                        ladder_thr_reg[i] <= cfg_data[16*i +: 16];
                    end
                end
                ctp_pkg::REG_LADDER_INTERVALS:
                begin
                    for (int i = 0; i < LADDER_ENTRIES; i++)
                    begin
                        ladder_ivl_reg[i] <= cfg_data[16*i +: 16];
                    end
                end
                ctp_pkg::REG_BURST_FRAMES:     burst_frames_reg   <= cfg_data[7:0];
                ctp_pkg::REG_BURST_INTERVAL:   burst_interval_reg <= cfg_data[15:0];
            endcase
        end
    end

    // Cooldown is the longer of one second and a full burst span, each
    // factor counted as at least one.
    always_comb
    begin
        frames_eff   = (burst_frames_reg == 8'd0) ? 8'd1 : burst_frames_reg;
        interval_eff = (burst_interval_reg == 16'd0) ? 16'd1 : burst_interval_reg;
        span         = {16'd0, frames_eff} * {8'd0, interval_eff};
        cooldown_ms  = (span > ctp_pkg::MIN_COOLDOWN_MS) ? span : ctp_pkg::MIN_COOLDOWN_MS;
    end

    always_comb
    begin
        cfg.capture_mode         = mode_reg;
        cfg.min_interval_ms      = min_interval_reg;
        cfg.confidence_threshold = conf_thr_reg;
        cfg.ladder_count         = ladder_count_reg;
        cfg.burst_frames         = burst_frames_reg;
        cfg.burst_interval_ms    = burst_interval_reg;
        cfg.cooldown_ms          = cooldown_ms;
    end

    assign ladder_thr = ladder_thr_reg;
    assign ladder_ivl = ladder_ivl_reg;

endmodule

// ===== src/ctp_policy.sv =====
// Save decision and policy state of the capture trigger policy unit.
// Depends on ctp_pkg and the assertion macro header.
`include "capture_trigger_policy_unit_assert.svh"

module ctp_policy #(
    parameter int LADDER_ENTRIES = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  ctp_pkg::in_item_t   item,
    input  ctp_pkg::cfg_t       cfg,
    input  logic [15:0]         ladder_thr [LADDER_ENTRIES],
    input  logic [15:0]         ladder_ivl [LADDER_ENTRIES],
    output ctp_pkg::out_item_t  result
);

    logic [31:0] last_save_reg,      last_save_next;
    logic [31:0] last_conf_reg,      last_conf_next;
    logic [7:0]  burst_left_reg,     burst_left_next;
    logic [31:0] last_burst_reg,     last_burst_next;
    logic        burst_done_reg,     burst_done_next;
    logic        target_seen_reg,    target_seen_next;
    logic [2:0]  current_rung_reg,   current_rung_next;
    logic [15:0] cancel_count_reg,   cancel_count_next;

    logic [31:0] since_save;
    logic        confident;
    logic        cooled;
    logic        rung_found;
    logic [15:0] interval;
    logic        save;
    logic [2:0]  reason;
    logic [1:0]  rung_out;

    always_comb
    begin
        last_save_next    = last_save_reg;
        last_conf_next    = last_conf_reg;
        burst_left_next   = burst_left_reg;
        last_burst_next   = last_burst_reg;
        burst_done_next   = burst_done_reg;
        target_seen_next  = target_seen_reg;
        current_rung_next = current_rung_reg;
        cancel_count_next = cancel_count_reg;
        since_save        = item.time_ms - last_save_reg;
        confident         = item.has_detection && (item.top_score >= cfg.confidence_threshold);
        cooled            = 1'b0;
        rung_found        = 1'b0;
        interval          = '0;
        save              = 1'b0;
        reason            = ctp_pkg::REASON_NONE;
        rung_out          = '0;

        if (cfg.capture_mode == ctp_pkg::MODE_DETECTION)
        begin
            if (item.has_detection && since_save >= {16'd0, cfg.min_interval_ms})
            begin
                save   = 1'b1;
                reason = ctp_pkg::REASON_DETECTION;
            end
        end
        else if (cfg.capture_mode == ctp_pkg::MODE_BURST)
        begin
            if (confident)
            begin
                last_conf_next   = item.time_ms;
                target_seen_next = 1'b1;
            end
            else if (target_seen_reg && (item.time_ms - last_conf_reg) > ctp_pkg::FADE_MS)
            begin
                target_seen_next = 1'b0;
            end

            if (item.has_detection)
            begin
                // Any detection cuts short a burst in flight; a confident one also counts it as cancelled.
                if (confident && burst_left_reg != 8'd0)
                begin
                    burst_done_next = 1'b1;
                    if (cancel_count_reg != ctp_pkg::CANCEL_MAX)
                    begin
                        cancel_count_next = cancel_count_reg + 16'd1;
                    end
                end
                burst_left_next = '0;
                // The lowest rung whose threshold the score reaches wins.
                for (int i = 0; i < LADDER_ENTRIES; i++)
                begin
                    if (!rung_found && 3'(i) < cfg.ladder_count
                        && item.top_score >= ladder_thr[i])
                    begin
                        rung_found        = 1'b1;
                        interval          = ladder_ivl[i];
                        current_rung_next = 3'(i);
                    end
                end
            end
            else if (target_seen_next)
            begin
                cooled = (last_burst_reg == 32'd0)
                      || ((item.time_ms - last_burst_reg) >= {8'd0, cfg.cooldown_ms});
                if (burst_left_reg == 8'd0 && !burst_done_reg && cooled)
                begin
                    burst_left_next = cfg.burst_frames;
                    last_burst_next = item.time_ms;
                end
                if (burst_left_next != 8'd0)
                begin
                    interval          = cfg.burst_interval_ms;
                    current_rung_next = ctp_pkg::RUNG_BURST;
                end
                else
                begin
                    target_seen_next = 1'b0;
                    burst_done_next  = 1'b0;
                end
            end

            if (interval != 16'd0 && since_save >= {16'd0, interval})
            begin
                save = 1'b1;
                if (current_rung_next == ctp_pkg::RUNG_BURST)
                begin
                    reason = ctp_pkg::REASON_BURST;
                    if (burst_left_next != 8'd0)
                    begin
                        burst_left_next = burst_left_next - 8'd1;
                    end
                    if (burst_left_next == 8'd0)
                    begin
                        burst_done_next  = 1'b1;
                        target_seen_next = 1'b0;
                    end
                end
                else
                begin
                    reason   = ctp_pkg::REASON_LADDER;
                    rung_out = current_rung_next[1:0];
                end
            end
        end
        else
        begin
            // Timed mode; the unused mode code behaves the same way.
            if (since_save >= {16'd0, cfg.min_interval_ms})
            begin
                save   = 1'b1;
                reason = ctp_pkg::REASON_TIMED;
            end
        end

        if (save)
        begin
            last_save_next = item.time_ms;
        end

        result.save_frame       = save;
        result.save_reason      = reason;
        result.rung_index       = rung_out;
        result.bursts_cancelled = cancel_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_save_reg    <= '0;
            last_conf_reg    <= '0;
            burst_left_reg   <= '0;
            last_burst_reg   <= '0;
            burst_done_reg   <= 1'b0;
            target_seen_reg  <= 1'b0;
            current_rung_reg <= '0;
            cancel_count_reg <= '0;
        end
        else if (fire)
        begin
            last_save_reg    <= last_save_next;
            last_conf_reg    <= last_conf_next;
            burst_left_reg   <= burst_left_next;
            last_burst_reg   <= last_burst_next;
            burst_done_reg   <= burst_done_next;
            target_seen_reg  <= target_seen_next;
            current_rung_reg <= current_rung_next;
            cancel_count_reg <= cancel_count_next;
        end
    end

    `CTP_ASSERT_NEXT(a_cancel_monotonic, 1'b1, cancel_count_reg >= $past(cancel_count_reg), "cancel count went down")
    `CTP_ASSERT_NEXT(a_state_holds_idle, !fire, $stable(burst_left_reg) && $stable(last_save_reg), "policy state changed without a decision")

endmodule
